@@ src/pmf_pkg.sv @@
// ----------------------------------------------------------------------------
// Paced message FIFO package
// Sizes, operation and status codes used by the paced message FIFO unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pmf_pkg;

    // Queue geometry.
    localparam int QUEUE_DEPTH = 8;
    localparam int MAX_PAYLOAD = 64;

    localparam int QIDX_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int POS_W     = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int WP_W      = $clog2(MAX_PAYLOAD + 1);
    localparam int PAY_DEPTH = QUEUE_DEPTH * MAX_PAYLOAD;
    localparam int PAY_AW    = (PAY_DEPTH > 1) ? $clog2(PAY_DEPTH) : 1;

    // Fixed field widths.
    localparam int OP_W     = 3;
    localparam int BYTE_W   = 8;
    localparam int STAT_W   = 3;
    localparam int LEN_W    = 7;
    localparam int ECNT_W   = 4;
    localparam int TIME_W   = 32;
    localparam int PACE_W   = 16;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // Register indexes on the configuration port.
    localparam logic REG_PACING = 1'b0;

    localparam logic [PACE_W-1:0] PACING_RESET = 16'd1000;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 3'd0,
        OP_POP   = 3'd1,
        OP_CLEAR = 3'd2,
        OP_MARK  = 3'd3,
        OP_TICK  = 3'd4
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        STAT_BYTE  = 3'd0,
        STAT_DONE  = 3'd1,
        STAT_FULL  = 3'd2,
        STAT_LONG  = 3'd3,
        STAT_EMPTY = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        DROP_NONE = 2'd0,
        DROP_FULL = 2'd1,
        DROP_LONG = 2'd2
    } t_drop;

endpackage

`default_nettype wire

@@ src/pmf_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pmf_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ src/paced_message_fifo_unit.sv @@
// ----------------------------------------------------------------------------
// Paced message FIFO
// Ring queue of length-tagged messages with a millisecond pacing timer.
// ----------------------------------------------------------------------------
// Push, clear, mark-sent and tick operations each give one result beat, so they
// sustain one item per cycle while results are taken. A pop of a message of L
// bytes first reads the stored length and the first byte, then gives one result
// beat per byte, paced by the single read port of the payload RAM. A pop of an
// empty queue gives one result beat. No new item is accepted while a pop is
// streaming. The payload and length stores have no reset; only entries that
// were written are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module paced_message_fifo_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,

    // Input channel.
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [pmf_pkg::OP_W-1:0]   i_operation,
    input  wire logic [pmf_pkg::BYTE_W-1:0] i_data_byte,
    input  wire logic                       i_last_byte,

    // Result channel.
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [pmf_pkg::STAT_W-1:0]      o_status,
    output logic [pmf_pkg::BYTE_W-1:0]      o_out_byte,
    output logic                            o_out_last,
    output logic [pmf_pkg::LEN_W-1:0]       o_message_length,
    output logic [pmf_pkg::ECNT_W-1:0]      o_entry_count,
    output logic                            o_can_send,

    // Configuration port.
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [pmf_pkg::APB_AW-1:0] paddr,
    input  wire logic [pmf_pkg::APB_DW-1:0] pwdata,
    output logic [pmf_pkg::APB_DW-1:0]      prdata,
    output logic                            pready
);

    import pmf_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_POP
    } t_state;

    // Control registers and their next values.
    t_state              r_state,   n_state;
    logic [QIDX_W-1:0]   r_head,    n_head;
    logic [QIDX_W-1:0]   r_tail,    n_tail;
    logic [CNT_W-1:0]    r_count,   n_count;
    logic [WP_W-1:0]     r_wpos,    n_wpos;
    t_drop               r_drop,    n_drop;
    logic [TIME_W-1:0]   r_now,     n_now;
    logic [TIME_W-1:0]   r_next,    n_next;
    logic [PACE_W-1:0]   r_pacing;
    logic [QIDX_W-1:0]   r_slot,    n_slot;
    logic [POS_W-1:0]    r_idx,     n_idx;

    // Output register.
    logic                r_out_valid, n_out_valid;
    t_status             r_status,    n_status;
    logic [BYTE_W-1:0]   r_out_byte,  n_out_byte;
    logic                r_out_last,  n_out_last;
    logic [LEN_W-1:0]    r_len,       n_len;
    logic [ECNT_W-1:0]   r_ecnt,      n_ecnt;
    logic                r_can_send,  n_can_send;

    // Memory ports.
    logic                pay_we;
    logic [PAY_AW-1:0]   pay_waddr;
    logic [PAY_AW-1:0]   pay_raddr;
    logic [BYTE_W-1:0]   pay_rdata;
    logic                len_we;
    logic [QIDX_W-1:0]   len_raddr;
    logic [LEN_W-1:0]    len_wdata;
    logic [LEN_W-1:0]    len_rdata;

    // Working values.
    logic                out_free;
    logic                accept;
    logic                cfg_write;
    t_drop               drop;
    logic [WP_W-1:0]     wpos_inc;
    logic [WP_W-1:0]     pop_len;
    logic                pop_fin;
    logic [WP_W-1:0]     idx_inc;

    function automatic logic [QIDX_W-1:0] advance(input logic [QIDX_W-1:0] idx);
        advance = (idx == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [PAY_AW-1:0] pay_addr(input logic [QIDX_W-1:0] slot,
                                                   input logic [POS_W-1:0]  pos);
        pay_addr = PAY_AW'(slot) * PAY_AW'(MAX_PAYLOAD) + PAY_AW'(pos);
    endfunction

    function automatic t_status drop_status(input t_drop d);
        drop_status = (d == DROP_FULL) ? STAT_FULL : STAT_LONG;
    endfunction

    // Payload bytes, one slot of MAX_PAYLOAD bytes per message.
    pmf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PAY_DEPTH)
    ) u_payload_ram (
        .i_clk   (i_clk),
        .i_we    (pay_we),
        .i_waddr (pay_waddr),
        .i_wdata (i_data_byte),
        .i_raddr (pay_raddr),
        .o_rdata (pay_rdata)
    );

    // Stored length per slot.
    pmf_ram #(
        .WIDTH (LEN_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_length_ram (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (r_tail),
        .i_wdata (len_wdata),
        .i_raddr (len_raddr),
        .o_rdata (len_rdata)
    );

    // Handshakes.
    assign out_free  = !r_out_valid || i_ready;
    assign o_ready   = (r_state == ST_IDLE) && out_free;
    assign accept    = i_valid && o_ready;
    assign cfg_write = psel && penable && pwrite && pready;

    // Length of the message being popped, clamped to the legal range.
    always_comb begin
        if (len_rdata == '0) begin
            pop_len = WP_W'(1);
        end else if (len_rdata > LEN_W'(MAX_PAYLOAD)) begin
            pop_len = WP_W'(MAX_PAYLOAD);
        end else begin
            pop_len = WP_W'(len_rdata);
        end
    end

    assign idx_inc  = WP_W'(r_idx) + 1'b1;
    assign pop_fin  = (idx_inc == pop_len);
    assign wpos_inc = r_wpos + 1'b1;

    // Next-state logic for the queue, the timer and the output register.
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_wpos      = r_wpos;
        n_drop      = r_drop;
        n_now       = r_now;
        n_next      = r_next;
        n_slot      = r_slot;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_ready;
        n_status    = r_status;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_len       = r_len;
        n_ecnt      = r_ecnt;
        n_can_send  = r_can_send;
        drop        = r_drop;
        pay_we      = 1'b0;
        pay_waddr   = pay_addr(r_tail, r_wpos[POS_W-1:0]);
        len_we      = 1'b0;
        len_wdata   = LEN_W'(wpos_inc);
        len_raddr   = r_head;
        pay_raddr   = pay_addr(r_head, '0);

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    // Most operations answer with one beat and no payload.
                    n_out_valid = 1'b1;
                    n_status    = STAT_DONE;
                    n_out_byte  = '0;
                    n_out_last  = 1'b1;
                    n_len       = '0;

                    unique case (t_op'(i_operation))
                        OP_PUSH: begin
                            // Fullness is judged on the first byte only.
                            if (r_wpos == '0 && drop == DROP_NONE &&
                                r_count >= CNT_W'(QUEUE_DEPTH)) begin
                                drop = DROP_FULL;
                            end
                            if (drop == DROP_NONE && r_wpos >= WP_W'(MAX_PAYLOAD)) begin
                                drop = DROP_LONG;
                            end
                            if (drop == DROP_NONE) begin
                                pay_we = 1'b1;
                                n_wpos = wpos_inc;
                            end
                            n_drop = drop;
                            if (i_last_byte) begin
                                if (drop == DROP_NONE) begin
                                    len_we   = 1'b1;
                                    n_tail   = advance(r_tail);
                                    n_count  = r_count + 1'b1;
                                    n_status = STAT_DONE;
                                end else begin
                                    n_status = drop_status(drop);
                                end
                                n_wpos = '0;
                                n_drop = DROP_NONE;
                            end else begin
                                n_status = (drop == DROP_NONE) ? STAT_BYTE
                                                               : drop_status(drop);
                            end
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                // Length and first byte arrive next cycle.
                                n_out_valid = r_out_valid && !i_ready;
                                n_status    = r_status;
                                n_out_byte  = r_out_byte;
                                n_out_last  = r_out_last;
                                n_len       = r_len;
                                n_slot      = r_head;
                                n_idx       = '0;
                                n_head      = advance(r_head);
                                n_count     = r_count - 1'b1;
                                n_state     = ST_POP;
                            end
                        end
                        OP_CLEAR: begin
                            n_head  = '0;
                            n_tail  = '0;
                            n_count = '0;
                            n_wpos  = '0;
                            n_drop  = DROP_NONE;
                        end
                        OP_MARK: begin
                            n_next = r_now + TIME_W'(r_pacing);
                        end
                        OP_TICK: begin
                            n_now = r_now + 1'b1;
                        end
                        default: begin
                        end
                    endcase

                    if (n_state == ST_IDLE) begin
                        n_ecnt     = ECNT_W'(n_count);
                        n_can_send = (n_now >= n_next);
                    end
                end
            end
            ST_POP: begin
                // Read data holds the byte at r_idx; keep or advance the address.
                len_raddr = r_slot;
                pay_raddr = pay_addr(r_slot, r_idx);
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = pop_fin ? STAT_DONE : STAT_BYTE;
                    n_out_byte  = pay_rdata;
                    n_out_last  = pop_fin;
                    n_len       = LEN_W'(pop_len);
                    n_ecnt      = ECNT_W'(r_count);
                    n_can_send  = (r_now >= r_next);
                    if (pop_fin) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx     = r_idx + 1'b1;
                        pay_raddr = pay_addr(r_slot, r_idx + 1'b1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State, configuration and output registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_wpos      <= '0;
            r_drop      <= DROP_NONE;
            r_now       <= '0;
            r_next      <= '0;
            r_pacing    <= PACING_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_wpos      <= n_wpos;
            r_drop      <= n_drop;
            r_now       <= n_now;
            r_next      <= n_next;
            r_out_valid <= n_out_valid;
            if (cfg_write && paddr[2] == REG_PACING) begin
                r_pacing <= pwdata[PACE_W-1:0];
            end
        end
        r_slot     <= n_slot;
        r_idx      <= n_idx;
        r_status   <= n_status;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_len      <= n_len;
        r_ecnt     <= n_ecnt;
        r_can_send <= n_can_send;
    end

    // Configuration read-back.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PACING) ? APB_DW'(r_pacing) : '0;

    // Result outputs.
    assign o_valid          = r_out_valid;
    assign o_status         = r_status;
    assign o_out_byte       = r_out_byte;
    assign o_out_last       = r_out_last;
    assign o_message_length = r_len;
    assign o_entry_count    = r_ecnt;
    assign o_can_send       = r_can_send;

`ifndef SYNTHESIS
    // The message count never runs past the queue depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("message count exceeds queue depth");

    // A partial push never holds more than one slot of bytes.
    a_wpos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wpos <= WP_W'(MAX_PAYLOAD))
        else $error("write position exceeds slot size");

    // A popped byte index stays inside the stored length of the message.
    a_pop_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POP) && $past(r_state == ST_POP) |-> (WP_W'(r_idx) < pop_len))
        else $error("pop index beyond message length");

    // An empty answer reports an empty queue.
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == STAT_EMPTY) |-> (o_entry_count == '0))
        else $error("empty status with messages held");
`endif

endmodule

`default_nettype wire
